// File: rtl/core/assert_macros.svh
// Assertion helpers for the console checker.
// Each use expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tccs_pkg.sv
`default_nettype none

package tccs_pkg;

   // Field widths of the item ports
   localparam int CMD_W  = 1;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 11;
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Control characters and blank cell
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'd0;
   localparam logic [BYTE_W-1:0] BLANK_ATTR   = 8'd7;
   localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};
   localparam int                TAB_STEP     = 4;

   // One cursor move request
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] code;
   } step_type;

endpackage

`default_nettype wire

// File: rtl/core/tccs_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/tccs_cursor.sv
`default_nettype none

// Linear cursor kept as row base plus column, so newline needs no divide
module tccs_cursor import tccs_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELL_COUNT = COLUMNS * ROWS,
   localparam int CUR_W = $clog2(CELL_COUNT + TAB_STEP),
   localparam int COL_W = $clog2(COLUMNS + TAB_STEP)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire step_type         step,
   output logic      [CUR_W-1:0] cursor,
   output logic      [CUR_W-1:0] cursor_next,
   output logic                  scroll
);

   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic [CUR_W-1:0] base_ff, base_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] inc;
   logic [COL_W-1:0] col_sum;
   logic [CUR_W-1:0] cur_sum;
   logic [CUR_W-1:0] cur_step, base_step;
   logic [COL_W-1:0] col_step;

   // Candidate position after one character
   always_comb begin
      inc     = (step.code == CHAR_TAB) ? COL_W'(TAB_STEP) : COL_W'(1);
      col_sum = col_ff + inc;
      cur_sum = cursor_ff + CUR_W'(inc);
      unique case (step.code)
         CHAR_NEWLINE: begin
            base_step = base_ff + CUR_W'(COLUMNS);
            col_step  = '0;
            cur_step  = base_step;
         end
         default: begin
            if (col_sum >= COL_W'(COLUMNS)) begin
               col_step  = col_sum - COL_W'(COLUMNS);
               base_step = base_ff + CUR_W'(COLUMNS);
            end else begin
               col_step  = col_sum;
               base_step = base_ff;
            end
            cur_step = cur_sum;
         end
      endcase
   end

   // Running off the grid pulls the cursor to the last row
   assign scroll = step.en && (cur_step >= CUR_W'(CELL_COUNT));

   always_comb begin
      cursor_in = cursor_ff;
      base_in   = base_ff;
      col_in    = col_ff;
      if (scroll) begin
         cursor_in = CUR_W'((ROWS - 1) * COLUMNS);
         base_in   = CUR_W'((ROWS - 1) * COLUMNS);
         col_in    = '0;
      end else if (step.en) begin
         cursor_in = cur_step;
         base_in   = base_step;
         col_in    = col_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         base_ff   <= '0;
         col_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         base_ff   <= base_in;
         col_ff    <= col_in;
      end
   end

   assign cursor      = cursor_ff;
   assign cursor_next = cursor_in;

endmodule

`default_nettype wire

// File: rtl/core/tccs_sweep.sv
`default_nettype none

// Whole-store sweep: clears after reset, scrolls one row up on request.
// Read at idx+COLUMNS, write at idx in the next cycle.
module tccs_sweep import tccs_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELL_COUNT = COLUMNS * ROWS,
   localparam int ADDR_W = $clog2(CELL_COUNT)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rd_en,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [CELL_W-1:0] rd_data,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [CELL_W-1:0] wr_data
);

   logic              active_ff, active_in;
   logic              copy_ff, copy_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              wvalid_ff;
   logic [ADDR_W-1:0] waddr_ff;
   logic              wcopy_ff;
   logic              last;
   logic              src_ok;

   assign last   = (idx_ff == ADDR_W'(CELL_COUNT - 1));
   assign src_ok = copy_ff && (idx_ff < ADDR_W'(CELL_COUNT - COLUMNS));

   // Source row read
   assign rd_en   = active_ff && src_ok;
   assign rd_addr = idx_ff + ADDR_W'(COLUMNS);

   always_comb begin
      active_in = active_ff;
      copy_in   = copy_ff;
      idx_in    = idx_ff;
      if (active_ff) begin
         if (last) begin
            active_in = 1'b0;
            idx_in    = '0;
         end else begin
            idx_in = idx_ff + ADDR_W'(1);
         end
      end else if (start) begin
         active_in = 1'b1;
         copy_in   = 1'b1;
         idx_in    = '0;
      end
   end

   // Reset launches the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         copy_ff   <= 1'b0;
         idx_ff    <= '0;
         wvalid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         copy_ff   <= copy_in;
         idx_ff    <= idx_in;
         wvalid_ff <= active_ff;
      end
   end

   // Write stage payload
   always_ff @(posedge clock) begin
      waddr_ff <= idx_ff;
      wcopy_ff <= src_ok;
   end

   assign wr_en   = wvalid_ff;
   assign wr_addr = waddr_ff;
   assign wr_data = wcopy_ff ? rd_data : BLANK_CELL;
   assign busy    = active_ff || wvalid_ff;

endmodule

`default_nettype wire

// File: rtl/core/text_console_cursor_scroll_unit.sv
`default_nettype none

// Channel  Dir  Handshake              Fields
// req      in   req_valid / req_stall  cmd, char_code, cell_index
// rsp      out  rsp_valid / rsp_stall  cursor_pos, read_char, read_attr
//
// In its accept cycle an item reads the cell store; the ST_EXEC state then
// modifies and writes the cell and loads the result register.
// The ST_EXEC state is there because the cell store read is registered.
// A write that runs the cursor off the grid starts a scroll sweep, and
// req_stall stays high until it ends.
// Reset starts a clearing pass with req_stall high.
// A stalled result waits in the output register; the ST_EXEC state
// holds until that register frees.
module text_console_cursor_scroll_unit import tccs_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [BYTE_W-1:0] req_char_code,
   input  wire logic [IDX_W-1:0]  req_cell_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [POS_W-1:0]  rsp_cursor_pos,
   output logic      [BYTE_W-1:0] rsp_read_char,
   output logic      [BYTE_W-1:0] rsp_read_attr
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CUR_W      = $clog2(CELL_COUNT + TAB_STEP);
   localparam int EXT_W      = (CUR_W > POS_W) ? CUR_W : POS_W;
   localparam int IDXX_W     = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;

   // Item sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff, state_in;
   logic              op_cmd_ff;
   logic [BYTE_W-1:0] op_code_ff;
   logic              op_hit_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [BYTE_W-1:0] rsp_char_ff;
   logic [BYTE_W-1:0] rsp_attr_ff;

   logic              accept;
   logic              done;
   logic              store_char;
   logic [IDXX_W-1:0] idx_ext;
   logic              idx_hit;
   logic [EXT_W-1:0]  cur_ext;

   step_type          step;
   logic [CUR_W-1:0]  cursor;
   logic [CUR_W-1:0]  cursor_next;
   logic              scroll;

   logic              sw_busy;
   logic              sw_rd_en, sw_wr_en;
   logic [ADDR_W-1:0] sw_rd_addr, sw_wr_addr;
   logic [CELL_W-1:0] sw_wr_data;

   logic              ram_rd_en, ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr, ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

   // Handshake
   assign req_stall = (state_ff != ST_IDLE) || sw_busy;
   assign accept    = req_valid && !req_stall;
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Read index range check
   assign idx_ext = IDXX_W'(req_cell_index);
   assign idx_hit = (idx_ext < IDXX_W'(CELL_COUNT));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Captured item
   always_ff @(posedge clock) begin
      if (accept) begin
         op_cmd_ff  <= req_cmd;
         op_code_ff <= req_char_code;
         op_hit_ff  <= idx_hit;
      end
   end

   // Cursor moves when a write item completes
   assign step.en    = done && (op_cmd_ff == CMD_WRITE);
   assign step.code  = op_code_ff;
   assign store_char = step.en && (op_code_ff != CHAR_NEWLINE) && (op_code_ff != CHAR_TAB);

   tccs_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cursor      (cursor),
      .cursor_next (cursor_next),
      .scroll      (scroll)
   );

   tccs_sweep #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .start   (scroll),
      .busy    (sw_busy),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (sw_wr_en),
      .wr_addr (sw_wr_addr),
      .wr_data (sw_wr_data)
   );

   // Memory port: the sweep owns it while busy
   always_comb begin
      if (sw_busy) begin
         ram_rd_en   = sw_rd_en;
         ram_rd_addr = sw_rd_addr;
         ram_wr_en   = sw_wr_en;
         ram_wr_addr = sw_wr_addr;
         ram_wr_data = sw_wr_data;
      end else begin
         ram_rd_en   = accept;
         ram_rd_addr = (req_cmd == CMD_READ) ? idx_ext[ADDR_W-1:0] : cursor[ADDR_W-1:0];
         ram_wr_en   = store_char;
         ram_wr_addr = cursor[ADDR_W-1:0];
         ram_wr_data = {ram_rd_data[CELL_W-1:BYTE_W], op_code_ff};
      end
   end

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result register
   assign cur_ext = EXT_W'(cursor_next);

   always_comb begin
      if (done) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_pos_ff <= cur_ext[POS_W-1:0];
         if ((op_cmd_ff == CMD_READ) && op_hit_ff) begin
            rsp_char_ff <= ram_rd_data[BYTE_W-1:0];
            rsp_attr_ff <= ram_rd_data[CELL_W-1:BYTE_W];
         end else begin
            rsp_char_ff <= '0;
            rsp_attr_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_read_attr  = rsp_attr_ff;

endmodule

`default_nettype wire

// File: rtl/core/tccs_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks for the console unit
module tccs_checker import tccs_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [CMD_W-1:0]  req_cmd,
   input wire logic [BYTE_W-1:0] req_char_code,
   input wire logic [IDX_W-1:0]  req_cell_index,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [POS_W-1:0]  rsp_cursor_pos,
   input wire logic [BYTE_W-1:0] rsp_read_char,
   input wire logic [BYTE_W-1:0] rsp_read_attr
);

   localparam int CELL_COUNT = COLUMNS * ROWS;

   logic                            req_take;
   logic                            rsp_free;
   logic [CMD_W+BYTE_W+IDX_W-1:0]   req_word;
   logic [POS_W+2*BYTE_W-1:0]       rsp_word;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid || !rsp_stall;
   assign req_word = {req_cmd, req_char_code, req_cell_index};
   assign rsp_word = {rsp_cursor_pos, rsp_read_char, rsp_read_attr};

   // A stalled item stays offered and unchanged
   `CHK_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_word), "stalled item changed")

   // A pending result survives a stall unchanged
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result lost under stall")

   // One item in flight: the cycle after an accept is stalled
   `CHK_NEXT(a_one_item, req_take, req_stall, "item accepted while busy")

   // An item's result is registered and shows when the output side is free
   `CHK_NEXT(a_rsp_latency, req_take ##1 rsp_free, rsp_valid, "result missing after item")

   // Cursor stays on the grid
   `CHK_IMPL(a_cursor_range, rsp_valid, 32'(rsp_cursor_pos) < CELL_COUNT, "cursor off grid")

endmodule

bind text_console_cursor_scroll_unit tccs_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tccs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .req_char_code  (req_char_code),
   .req_cell_index (req_cell_index),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_read_char  (rsp_read_char),
   .rsp_read_attr  (rsp_read_attr)
);

`default_nettype wire
